### hw/rtl/mcg_pkg.sv
`default_nettype none

package mcg_pkg;

  // Storage geometry
  localparam int CHORD_SLOTS = 8;
  localparam int NOTE_W      = 8;
  localparam int ENTRY_W     = CHORD_SLOTS * NOTE_W;
  localparam int LIST_N      = 2 * CHORD_SLOTS;
  localparam int SEL_W       = $clog2(LIST_N);
  localparam int KEYS        = 128;
  localparam int KEY_W       = 7;

  // Stream payload widths
  localparam int IN_W  = 56;
  localparam int OUT_W = 56;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_POINT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHORD_MAP   = 2'd1;

  localparam logic [6:0]            SPLIT_RESET     = 7'd60;
  localparam logic [CFG_DATA_W-1:0] CHORD_MAP_RESET = 48'hCBA9_8765_4321;

  // MIDI codes
  localparam logic [7:0] EMPTY_SLOT      = 8'hFF;
  localparam logic [7:0] CLASS_MASK      = 8'hE0;
  localparam logic [7:0] NOTE_CLASS      = 8'h80;
  localparam logic [7:0] NOTE_ON_MASK    = 8'h90;
  localparam logic [7:0] OFF_STATUS_MASK = 8'h8F;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_BUILD,
    ST_EMIT
  } mcg_state_t;

  typedef struct packed {
    logic capture;
    logic build;
    logic emit;
  } mcg_cmd_t;

  typedef struct packed {
    logic pending;
    logic single;
    logic out_free;
  } mcg_stat_t;

  // Chord shapes, semitone offsets, slot 0 in the low byte; 0xFF is an unused slot.
  // Unlisted indices fall back to the bare root.
  function automatic logic [63:0] shape_lookup(input logic [3:0] idx);
    logic [63:0] s;
    case (idx)
      4'd1:    s = 64'hFFFF_FFFF_FF07_0400;
      4'd2:    s = 64'hFFFF_FFFF_0B07_0400;
      4'd3:    s = 64'hFFFF_FFFF_FF0B_0704;
      4'd4:    s = 64'hFFFF_FFFF_0C09_0502;
      4'd5:    s = 64'hFFFF_FFFF_FF0E_0B07;
      4'd6:    s = 64'hFFFF_FFFF_FF11_0E0B;
      4'd7:    s = 64'hFFFF_FFFF_0E0B_0704;
      4'd8:    s = 64'hFFFF_FFFF_FF09_0502;
      4'd9:    s = 64'hFFFF_FFFF_100C_0905;
      4'd10:   s = 64'hFFFF_FFFF_FF0C_0905;
      4'd11:   s = 64'hFFFF_FFFF_110E_0B07;
      4'd12:   s = 64'hFFFF_FFFF_FF10_0C09;
      default: s = 64'hFFFF_FFFF_FFFF_FF00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mcg_ctrl.sv
`default_nettype none

module mcg_ctrl import mcg_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire mcg_stat_t stat,
  output mcg_cmd_t       cmd
);

  mcg_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_READ;
      end
      ST_READ:  state_nxt = ST_BUILD;
      ST_BUILD: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!stat.pending) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free && stat.single) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.build   = 1'b0;
    cmd.emit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_READ: ;
      ST_BUILD: cmd.build = 1'b1;
      ST_EMIT:  cmd.emit  = stat.pending && stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/mcg_dp.sv
`default_nettype none

module mcg_dp import mcg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mcg_cmd_t              cmd,
  output mcg_stat_t                  stat,
  input  wire logic [IN_W-1:0]       in_tdata,
  input  wire logic                  cfg_wr,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_W-1:0]           out_tdata,
  output logic                       out_tlast
);

  // Captured event
  logic [15:0] time_r;
  logic [2:0]  count_r;
  logic [7:0]  status_r;
  logic [7:0]  d1_r;
  logic [7:0]  d2_r;
  logic [7:0]  d3_r;

  // Configuration and tonic
  logic [6:0]            split_r;
  logic [CFG_DATA_W-1:0] chord_map_r;
  logic [3:0]            tonic_r;

  // Held-notes RAM with per-key valid flags
  logic [ENTRY_W-1:0] held_mem [KEYS];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [KEYS-1:0]    valid_r;

  // Result list
  logic [ENTRY_W-1:0] held_r;
  logic [ENTRY_W-1:0] chord_r;
  logic [LIST_N-1:0]  mask_r;
  logic               pass_r;

  // Output register
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;
  logic             out_tlast_r;

  // Decode
  logic                is_note;
  logic                note_on;
  logic                below;
  logic                in_mod_oct;
  logic                play;
  logic [KEY_W-1:0]    key;
  logic [12:0]         prod;
  logic [3:0]          quot;
  logic [6:0]          q12;
  logic [6:0]          pc_full;
  logic [3:0]          pc;
  logic [3:0]          chord_idx;
  logic [63:0]         shape;
  logic [7:0]          base;
  logic [ENTRY_W-1:0]  chord_new;
  logic [ENTRY_W-1:0]  held_cur;
  logic [ENTRY_W-1:0]  wr_entry;
  logic [8:0]          tonic_sum;
  logic [LIST_N-1:0]   list_mask;
  logic [7:0]          off;
  logic [8:0]          nsum;

  // Emit selection
  logic [SEL_W-1:0]      sel;
  logic [2*ENTRY_W-1:0]  list_all;
  logic [7:0]            sel_note;
  logic                  sel_release;
  logic [7:0]            o_status;
  logic [7:0]            o_note;
  logic [7:0]            o_vel;

  // Capture input transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      time_r   <= in_tdata[15:0];
      count_r  <= in_tdata[18:16];
      status_r <= in_tdata[26:19];
      d1_r     <= in_tdata[34:27];
      d2_r     <= in_tdata[42:35];
      d3_r     <= in_tdata[50:43];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r     <= SPLIT_RESET;
      chord_map_r <= CHORD_MAP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_SPLIT_POINT: split_r     <= cfg_data[6:0];
        CFG_CHORD_MAP:   chord_map_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Event classification and chord build
  always_comb begin
    is_note    = (count_r > 3'd2) && ((status_r & CLASS_MASK) == NOTE_CLASS);
    note_on    = ((status_r & NOTE_ON_MASK) == NOTE_ON_MASK) && (d2_r != 8'd0);
    below      = {1'b0, d1_r} < {2'b00, split_r};
    in_mod_oct = ({1'b0, d1_r} + 9'd12) >= {2'b00, split_r};
    play       = !below && !d1_r[7];
    key        = d1_r[KEY_W-1:0];
    tonic_sum  = {1'b0, d1_r} + 9'd12 - {2'b00, split_r};

    // note / 12 by reciprocal, exact for 0..127
    prod      = {6'd0, key} * 13'd43;
    quot      = prod[12:9];
    q12       = {quot, 3'b000} + {1'b0, quot, 2'b00};
    pc_full   = key - q12;
    pc        = pc_full[3:0];
    chord_idx = chord_map_r[{pc, 2'b00} +: 4];
    shape     = shape_lookup(chord_idx);
    base      = {1'b0, q12} + {4'd0, tonic_r};

    chord_new = '0;
    off       = '0;
    nsum      = '0;
    for (int i = 0; i < CHORD_SLOTS; i++) begin
      off  = shape[i*8 +: 8];
      nsum = {1'b0, base} + {1'b0, off};
      if (off == EMPTY_SLOT || nsum > 9'd127) begin
        chord_new[i*8 +: 8] = EMPTY_SLOT;
      end else begin
        chord_new[i*8 +: 8] = nsum[7:0];
      end
    end

    held_cur = valid_r[key] ? rd_data_r : {CHORD_SLOTS{EMPTY_SLOT}};
    wr_entry = note_on ? chord_new : {CHORD_SLOTS{EMPTY_SLOT}};

    // Release slots first, then new chord slots
    list_mask = '0;
    for (int i = 0; i < CHORD_SLOTS; i++) begin
      list_mask[i]               = !held_cur[i*8 + 7];
      list_mask[CHORD_SLOTS + i] = !wr_entry[i*8 + 7];
    end
  end

  // Held-notes RAM: write on play keys, registered read
  always_ff @(posedge clk) begin
    if (cmd.build && is_note && play) begin
      held_mem[key] <= wr_entry;
    end
    rd_data_r <= held_mem[key];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.build && is_note && play) begin
      valid_r[key] <= 1'b1;
    end
  end

  // Tonic update from modifier keys
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tonic_r <= '0;
    end else if (cmd.build && is_note && below && in_mod_oct && note_on) begin
      tonic_r <= tonic_sum[3:0];
    end
  end

  // Result list
  always_ff @(posedge clk) begin
    if (cmd.build) begin
      pass_r  <= !is_note;
      held_r  <= held_cur;
      chord_r <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cmd.build) begin
      if (!is_note) begin
        mask_r <= LIST_N'(1);
      end else if (play) begin
        mask_r <= list_mask;
      end else begin
        mask_r <= '0;
      end
    end else if (cmd.emit) begin
      mask_r <= mask_r & ~(LIST_N'(1) << sel);
    end
  end

  // Pick lowest pending result
  always_comb begin
    sel = '0;
    for (int i = LIST_N - 1; i >= 0; i--) begin
      if (mask_r[i]) sel = SEL_W'(i);
    end
    list_all    = {chord_r, held_r};
    sel_note    = list_all[{sel, 3'b000} +: 8];
    sel_release = sel < SEL_W'(CHORD_SLOTS);

    if (pass_r) begin
      o_status = status_r;
      o_note   = d1_r;
      o_vel    = d2_r;
    end else if (sel_release) begin
      o_status = status_r & OFF_STATUS_MASK;
      o_note   = sel_note;
      o_vel    = 8'd0;
    end else begin
      o_status = status_r;
      o_note   = sel_note;
      o_vel    = d2_r;
    end
  end

  assign stat.pending  = |mask_r;
  assign stat.single   = (mask_r & (mask_r - LIST_N'(1))) == '0;
  assign stat.out_free = !out_tvalid_r || out_tready;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata_r <= {5'd0, d3_r, o_vel, o_note, o_status, count_r, time_r};
      out_tlast_r <= stat.single;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

`default_nettype wire

### hw/rtl/midi_chord_generator.sv
`default_nettype none

// Channel   Direction  Transfer when             Payload
// in_*      input      in_tvalid & in_tready     tdata: one MIDI event
// out_*     output     out_tvalid & out_tready   tdata: one result, tlast: last of event
// cfg_*     input      cfg_valid & cfg_ready     cfg_index, cfg_data
//
// Each event passes through accept, held-notes RAM read and chord build, then
// the emit phase sends its results, or passes empty when there are none;
// an event gives at most 8 results (four held notes released, four new ones).
// Results leave through a single output register, so a stalled out_tready stretches
// the emit phase cycle for cycle. After reset all 128 keys read as empty at once
// (per-key valid flops); no clearing pass. cfg_ready is always high.

module midi_chord_generator import mcg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // time_offset[15:0], byte_count[18:16], status_byte[26:19], data_one[34:27],
  // data_two[42:35], data_three[50:43], zero[55:51]
  input  wire logic [IN_W-1:0]       in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_time_offset[15:0], out_byte_count[18:16], out_status[26:19],
  // out_note[34:27], out_velocity[42:35], out_extra[50:43], zero[55:51]
  output logic [OUT_W-1:0]           out_tdata,
  output logic                       out_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  mcg_cmd_t  cmd;
  mcg_stat_t stat;

  assign cfg_ready = 1'b1;

  mcg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mcg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### tb/midi_chord_generator_checker.sv
`default_nettype none

module midi_chord_generator_checker import mcg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  // time_offset, byte_count, status_byte, data_one, data_two, data_three, zero pad
  input  wire logic [IN_W-1:0]       in_tdata,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  // out_time_offset, out_byte_count, out_status, out_note, out_velocity, out_extra, zero pad
  input  wire logic [OUT_W-1:0]      out_tdata,
  input  wire logic                  out_tlast,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         pending,
  output int                         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [6:0]  HOME_SPLIT = 7'd60;
  localparam logic [47:0] HOME_MAP   = 48'hCBA9_8765_4321;
  localparam int          TOP_NOTE   = 127;
  localparam int          LAST_SHAPE = 12;
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    logic [15:0] offset;
    logic [2:0]  count;
    logic [7:0]  status;
    logic [7:0]  note;
    logic [7:0]  velocity;
    logic [7:0]  extra;
    logic        last;
  } chord_msg_t;

  // Predicted block state
  logic [6:0]  split_pt;
  logic [47:0] chord_sel;
  logic [3:0]  tonic_pc;
  logic [7:0]  held [KEYS][CHORD_SLOTS];

  chord_msg_t due_q[$];
  int         errors = 0;

  // Semitone offsets of each chord shape; 0 and unknown indices give the bare root
  function automatic logic [7:0] interval_of(int shape, int slot);
    logic [0:7][7:0] row;
    case (shape)
      1:  row = {8'd0,  8'd4,  8'd7,  {5{EMPTY_SLOT}}};
      2:  row = {8'd0,  8'd4,  8'd7,  8'd11, {4{EMPTY_SLOT}}};
      3:  row = {8'd4,  8'd7,  8'd11, {5{EMPTY_SLOT}}};
      4:  row = {8'd2,  8'd5,  8'd9,  8'd12, {4{EMPTY_SLOT}}};
      5:  row = {8'd7,  8'd11, 8'd14, {5{EMPTY_SLOT}}};
      6:  row = {8'd11, 8'd14, 8'd17, {5{EMPTY_SLOT}}};
      7:  row = {8'd4,  8'd7,  8'd11, 8'd14, {4{EMPTY_SLOT}}};
      8:  row = {8'd2,  8'd5,  8'd9,  {5{EMPTY_SLOT}}};
      9:  row = {8'd5,  8'd9,  8'd12, 8'd16, {4{EMPTY_SLOT}}};
      10: row = {8'd5,  8'd9,  8'd12, {5{EMPTY_SLOT}}};
      11: row = {8'd7,  8'd11, 8'd14, 8'd17, {4{EMPTY_SLOT}}};
      12: row = {8'd9,  8'd12, 8'd16, {5{EMPTY_SLOT}}};
      default: row = {8'd0, {7{EMPTY_SLOT}}};
    endcase
    return row[slot];
  endfunction

  function automatic chord_msg_t compose(logic [15:0] ofs, logic [2:0] cnt, logic [7:0] st,
                                         logic [7:0] nt, logic [7:0] vel, logic [7:0] ex,
                                         logic last);
    chord_msg_t m;
    m.offset   = ofs;
    m.count    = cnt;
    m.status   = st;
    m.note     = nt;
    m.velocity = vel;
    m.extra    = ex;
    m.last     = last;
    return m;
  endfunction

  function automatic string show(chord_msg_t m);
    return $sformatf("ofs=%h cnt=%0d st=%h note=%h vel=%h ex=%h last=%b",
                     m.offset, m.count, m.status, m.note, m.velocity, m.extra, m.last);
  endfunction

  // Work out the results of one accepted event and queue them
  task automatic predict_event(input logic [IN_W-1:0] d);
    logic [15:0] ofs;
    logic [2:0]  cnt;
    logic [7:0]  st, nt, vel, ex, off;
    logic        on;
    int          first, shape, base, n, pc;
    chord_msg_t  m;
    ofs   = d[15:0];
    cnt   = d[18:16];
    st    = d[26:19];
    nt    = d[34:27];
    vel   = d[42:35];
    ex    = d[50:43];
    first = due_q.size();

    // not a note message: one result, unchanged
    if (!(cnt > 3'd2 && (st & CLASS_MASK) == NOTE_CLASS)) begin
      due_q.push_back(compose(ofs, cnt, st, nt, vel, ex, 1'b1));
      return;
    end

    on = ((st & NOTE_ON_MASK) == NOTE_ON_MASK) && vel != 8'd0;

    // modifier octave sets the tonic, anything lower is dropped
    if (nt < split_pt) begin
      if (nt + 12 >= split_pt && on) tonic_pc = 4'(nt + 12 - split_pt);
      return;
    end
    if (nt > TOP_NOTE) return;

    // release whatever this key still holds
    for (int i = 0; i < CHORD_SLOTS; i++) begin
      if (held[nt][i] <= TOP_NOTE)
        due_q.push_back(compose(ofs, cnt, st & OFF_STATUS_MASK, held[nt][i], 8'd0, ex, 1'b0));
      held[nt][i] = EMPTY_SLOT;
    end

    // sound the chord for this pitch class
    if (on) begin
      pc    = nt % 12;
      shape = chord_sel[4*pc +: 4];
      if (shape > LAST_SHAPE) shape = 0;
      base  = (nt / 12) * 12 + tonic_pc;
      for (int i = 0; i < CHORD_SLOTS; i++) begin
        off = interval_of(shape, i);
        if (off != EMPTY_SLOT) begin
          n = base + off;
          if (n <= TOP_NOTE) begin
            held[nt][i] = 8'(n);
            due_q.push_back(compose(ofs, cnt, st, 8'(n), vel, ex, 1'b0));
          end
        end
      end
    end

    if (due_q.size() > first) begin
      m = due_q.pop_back();
      m.last = 1'b1;
      due_q.push_back(m);
    end
  endtask

  always @(posedge clk) begin
    chord_msg_t seen, want;
    if (!rst_n) begin
      split_pt  = HOME_SPLIT;
      chord_sel = HOME_MAP;
      tonic_pc  = 4'd0;
      for (int k = 0; k < KEYS; k++)
        for (int j = 0; j < CHORD_SLOTS; j++)
          held[k][j] = EMPTY_SLOT;
      due_q.delete();
    end else begin
      // result transfer: compare with the oldest expectation
      if (out_tvalid && out_tready) begin
        seen = compose(out_tdata[15:0], out_tdata[18:16], out_tdata[26:19],
                       out_tdata[34:27], out_tdata[42:35], out_tdata[50:43], out_tlast);
        if (due_q.size() == 0) begin
          if (errors < REPORT_MAX) $display("unexpected result: %s", show(seen));
          errors++;
        end else begin
          want = due_q.pop_front();
          if (want != seen) begin
            if (errors < REPORT_MAX)
              $display("result mismatch: expected %s, actual %s", show(want), show(seen));
            errors++;
          end
        end
      end

      if (in_tvalid && in_tready) predict_event(in_tdata);

      // register write; unknown indices are ignored
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SPLIT_POINT) split_pt = cfg_data[6:0];
        else if (cfg_index == CFG_CHORD_MAP) chord_sel = cfg_data;
      end
    end
    pending    <= due_q.size();
    fail_count <= errors;
  end

endmodule

`default_nettype wire

### tb/midi_chord_generator_test.sv
`default_nettype none

module midi_chord_generator_test;
  import mcg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] MIDI_NOTE_OFF = 8'h80;
  localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 40;
  localparam int SETTLE       = 32;    // well over the worst-case event length
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  // Quiet cycles allowed: hold-off plus long random stalls on 8 results, several times over
  localparam int QUIET_LIMIT  = 4000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  wire logic             in_tready;
  wire logic             out_tvalid;
  wire logic [OUT_W-1:0] out_tdata;
  wire logic             out_tlast;
  wire logic             cfg_ready;

  int pending;
  int fail_count;

  int   send_idle  = 0;
  int   recv_stall = 0;
  logic hold_req   = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;
  int   quiet      = 0;
  logic [6:0] split_now = 7'd60;

  int phase_idle  [PHASES] = '{0, 83, 0, 20, 0, 20};
  int phase_stall [PHASES] = '{0, 0, 83, 20, 83, 20};

  midi_chord_generator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  midi_chord_generator_checker chord_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fail_count(fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("midi_chord_generator_test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [IN_W-1:0] midi_event(logic [15:0] ofs, logic [2:0] cnt,
                                                 logic [7:0] st, logic [7:0] d1,
                                                 logic [7:0] d2, logic [7:0] d3);
    return {5'b0, d3, d2, d1, st, cnt, ofs};
  endfunction

  function automatic logic [47:0] wide_random();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Mostly well-formed note traffic around the current split point, some noise
  function automatic logic [IN_W-1:0] random_event(int split);
    int         pick, nt, hi;
    logic [7:0] ch, st, vel;
    logic [2:0] cnt;
    pick = $urandom_range(99);
    ch   = 8'($urandom_range(15));
    cnt  = ($urandom_range(9) == 0) ? 3'($urandom_range(4, 7)) : 3'd3;
    vel  = 8'($urandom_range(1, 255));
    hi   = (split + 11 > 127) ? 127 : split + 11;
    nt   = $urandom_range(1) ? $urandom_range(split, hi) : $urandom_range(split, 127);
    st   = MIDI_NOTE_ON | ch;
    if (pick < 45) begin
      // play-key note-on, as set up above
    end else if (pick < 70) begin
      if ($urandom_range(1)) begin
        st  = MIDI_NOTE_OFF | ch;
        vel = 8'($urandom);
      end else begin
        vel = 8'd0;
      end
    end else if (pick < 80) begin
      if (split > 0) nt = $urandom_range((split > 12) ? split - 12 : 0, split - 1);
      if ($urandom_range(2) == 0) st = MIDI_NOTE_OFF | ch;
    end else if (pick < 84 && split > 12) begin
      nt = $urandom_range(0, split - 13);
    end else if (pick < 89) begin
      nt = $urandom_range(128, 255);
      if ($urandom_range(1)) st = MIDI_NOTE_OFF | ch;
    end else begin
      return midi_event(16'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom));
    end
    return midi_event(16'($urandom), cnt, st, 8'(nt), vel, 8'($urandom));
  endfunction

  // Offer one event, idling first at the sender's rate; returns at its transfer
  task automatic send_event(input logic [IN_W-1:0] ev);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tdata  <= ev;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering, let every expected result arrive, then let the block go quiet
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register write, then the channel is left idle before returning
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Split point write with junk in the unused upper bits
  task automatic set_split(input logic [6:0] v);
    logic [CFG_DATA_W-1:0] data;
    data      = wide_random();
    data[6:0] = v;
    split_now = v;
    write_reg(CFG_SPLIT_POINT, data);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events at reset settings: split 60, default chord map, tonic 0
    send_idle  = 30;
    recv_stall <= 30;
    send_event(midi_event(16'h0000, 3'd0, 8'h90, 8'd60, 8'd100, 8'h00));  // too short
    send_event(midi_event(16'hFFFF, 3'd2, 8'h95, 8'd64, 8'd127, 8'hFF));  // too short
    send_event(midi_event(16'h1234, 3'd3, 8'hF0, 8'hFF, 8'hFF, 8'hFF));   // system
    send_event(midi_event(16'h0001, 3'd3, 8'hA3, 8'd61, 8'd50, 8'h00));   // aftertouch
    send_event(midi_event(16'h0007, 3'd1, 8'hC5, 8'd3, 8'd0, 8'h00));     // program
    send_event(midi_event(16'h0100, 3'd3, 8'h90, 8'd60, 8'd100, 8'h11));  // major chord
    send_event(midi_event(16'h0101, 3'd3, 8'h93, 8'd60, 8'd1, 8'h22));    // retrigger
    send_event(midi_event(16'h0102, 3'd3, 8'h83, 8'd60, 8'd40, 8'h33));   // release
    send_event(midi_event(16'h0103, 3'd3, 8'h80, 8'd60, 8'd0, 8'h44));    // nothing held
    send_event(midi_event(16'h0104, 3'd3, 8'h90, 8'd55, 8'd64, 8'h00));   // tonic 7
    send_event(midi_event(16'h0105, 3'd3, 8'h90, 8'd71, 8'd90, 8'h00));
    send_event(midi_event(16'h0106, 3'd3, 8'h9F, 8'd71, 8'd0, 8'h55));    // zero velocity
    send_event(midi_event(16'h0107, 3'd3, 8'h80, 8'd48, 8'd64, 8'h00));   // modifier off
    send_event(midi_event(16'h0108, 3'd3, 8'h90, 8'd47, 8'd64, 8'h00));   // dropped
    send_event(midi_event(16'h0109, 3'd3, 8'h90, 8'd127, 8'd127, 8'h00)); // all above 127
    send_event(midi_event(16'h010A, 3'd3, 8'h90, 8'd48, 8'd64, 8'h00));   // tonic 0
    send_event(midi_event(16'h010B, 3'd3, 8'h90, 8'd120, 8'd70, 8'h00));  // top notes
    send_event(midi_event(16'h010C, 3'd3, 8'h90, 8'd124, 8'd70, 8'h00));  // partly clipped
    send_event(midi_event(16'h010D, 3'd3, 8'h90, 8'd200, 8'd70, 8'h00));  // no key entry
    send_event(midi_event(16'h010E, 3'd4, 8'h8A, 8'd255, 8'd0, 8'h00));   // no key entry
    send_event(midi_event(16'h010F, 3'd7, 8'h9F, 8'd62, 8'd255, 8'hAA));  // long count
    send_event(midi_event(16'h0110, 3'd4, 8'h8F, 8'd62, 8'd255, 8'hAA));
    send_event(midi_event(16'h0111, 3'd3, 8'h90, 8'd0, 8'd0, 8'h00));     // dropped
    send_event(midi_event(16'h0112, 3'd5, 8'h8C, 8'd120, 8'd9, 8'h00));   // release
    wait_drained();

    // Random phases, each under its own register settings and idle pattern
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          set_split(7'd60);
          write_reg(CFG_CHORD_MAP, CHORD_MAP_RESET);
        end
        1: begin
          set_split(7'd12);
          write_reg(CFG_CHORD_MAP, wide_random());
        end
        2: begin
          set_split(7'd114);
          write_reg(CFG_CHORD_MAP, {CFG_DATA_W{1'b1}});
        end
        3: begin
          write_reg(CFG_SPARE_A, wide_random());
          write_reg(CFG_SPARE_B, wide_random());
          set_split(7'd5);
          write_reg(CFG_CHORD_MAP, wide_random());
        end
        4: begin
          set_split(7'd0);
          write_reg(CFG_CHORD_MAP, '0);
        end
        default: begin
          set_split(7'd127);
          write_reg(CFG_CHORD_MAP, wide_random());
        end
      endcase
      send_idle  = phase_idle[p];
      recv_stall <= phase_stall[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // receiver holds off while the sender keeps offering
        if (p == 0 && i == 10) hold_req <= 1'b1;
        // sender pauses until the block has caught up
        if (p == 1 && i == 24) wait_drained();
        send_event(random_event(split_now));
      end
      wait_drained();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("midi_chord_generator_test passed");
    end else begin
      $display("midi_chord_generator_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/mcg_pkg.sv
hw/rtl/mcg_ctrl.sv
hw/rtl/mcg_dp.sv
hw/rtl/midi_chord_generator.sv
tb/midi_chord_generator_checker.sv
tb/midi_chord_generator_test.sv
